>>> hw/rtl/ows_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ows_pkg: shared types and constants for the ROM search block
// Item and result layouts, search state, status and request codes.
// ----------------------------------------------------------------------------
package ows_pkg;

  // Default ROM length in bits
  localparam int ROM_BITS_DEF = 64;

  // Widths of the search bookkeeping fields
  localparam int POS_W = 7;
  localparam int FAM_W = 4;

  // Bus commands
  localparam logic [7:0] CMD_SEARCH      = 8'hF0;
  localparam logic [7:0] CMD_COND_SEARCH = 8'hEC;

  // Zero branches below this position fall within the family byte
  localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;

  // Request codes
  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_BIT   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Status codes
  localparam logic [2:0] ST_CONTINUE  = 3'd0;
  localparam logic [2:0] ST_COMMAND   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_IDLE      = 3'd4;

  // One input item
  typedef struct packed {
    logic [1:0] req_type;
    logic       presence;
    logic       normal_search;
    logic       id_bit;
    logic       complement_bit;
  } in_t;

  // One result item
  typedef struct packed {
    logic [2:0]       status;
    logic             write_dir;
    logic             direction;
    logic [7:0]       command_byte;
    logic [63:0]      rom_address;
    logic             last_device;
    logic [FAM_W-1:0] family_discrepancy;
  } out_t;

  // Search control state carried between passes
  typedef struct packed {
    logic [POS_W-1:0] last_discrepancy;
    logic             last_device_found;
    logic [FAM_W-1:0] family_branch;
    logic [POS_W-1:0] bit_position;
    logic [POS_W-1:0] last_zero_position;
    logic             in_pass;
  } ctl_t;

endpackage

>>> hw/rtl/one_wire_rom_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_rom_search: ROM search walk controller
// Steps through a search pass one bus event at a time and reports the
// command to send, the branch bit to write and the found ROM.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    ows_pkg::in_t
//  out_     output     out_valid / out_stall  ows_pkg::out_t
//
// One item per cycle sustained while out_stall stays low; an item passes from
// its input transfer through the stage register and then the result register
// to its result transfer.
// The search state updates as an item moves from the stage to the result.
// Reset (synchronous, rst_n low) resets the search state and empties both registers.
// out_stall holds the result; the stage then holds and in_stall rises.
// ----------------------------------------------------------------------------
module one_wire_rom_search #(
  parameter int ROM_BITS = ows_pkg::ROM_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ows_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ows_pkg::out_t out_data
);

  ows_pkg::in_t          stage_r;
  logic                  stage_vld_r;
  ows_pkg::ctl_t         ctl_r;
  ows_pkg::ctl_t         ctl_nxt;
  logic [ROM_BITS-1:0]   rom_r;
  logic [ROM_BITS-1:0]   rom_nxt;
  ows_pkg::out_t         out_r;
  ows_pkg::out_t         res;
  logic                  out_vld_r;
  logic                  out_free;
  logic                  step_go;

  // Handshake: the result slot is free when empty or being taken
  assign out_free = !out_vld_r || !out_stall;
  assign step_go  = stage_vld_r && out_free;
  assign in_stall = stage_vld_r && !out_free;

  ows_step #(
    .ROM_BITS (ROM_BITS)
  ) u_step (
    .item    (stage_r),
    .ctl     (ctl_r),
    .rom     (rom_r),
    .ctl_nxt (ctl_nxt),
    .rom_nxt (rom_nxt),
    .res     (res)
  );

  // Stage register: capture an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (!in_stall) begin
      stage_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_r <= in_data;
    end
  end

  // Search state: advance when the staged item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.last_discrepancy   <= '0;
      ctl_r.last_device_found  <= 1'b0;
      ctl_r.family_branch      <= '0;
      ctl_r.bit_position       <= ows_pkg::POS_W'(1);
      ctl_r.last_zero_position <= '0;
      ctl_r.in_pass            <= 1'b0;
      rom_r                    <= '0;
    end else if (step_go) begin
      ctl_r <= ctl_nxt;
      rom_r <= rom_nxt;
    end
  end

  // Result register: hold until transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= stage_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // A found result always writes its final direction bit
  a_found_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ows_pkg::ST_FOUND) |-> out_data.write_dir)
    else $error("found result without direction write");

  // A command result carries one of the two search commands
  a_cmd_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ows_pkg::ST_COMMAND) |->
      (out_data.command_byte == ows_pkg::CMD_SEARCH ||
       out_data.command_byte == ows_pkg::CMD_COND_SEARCH))
    else $error("command result with bad command byte");

  // Within a pass the position stays inside the ROM
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.in_pass |-> (ctl_r.bit_position >= ows_pkg::POS_W'(1) &&
                       ctl_r.bit_position <= ows_pkg::POS_W'(ROM_BITS)))
    else $error("bit position out of range during a pass");

  // A not-found step leaves the search state cleared and the pass closed
  a_not_found_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step_go && res.status == ows_pkg::ST_NOT_FOUND) |=>
      (!ctl_r.last_device_found && ctl_r.family_branch == '0 &&
       ctl_r.last_discrepancy == '0 && !ctl_r.in_pass))
    else $error("not found did not clear the search state");

  // Input stalls only while a staged item is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (stage_vld_r && out_vld_r && out_stall))
    else $error("input stall without a blocked result");
`endif

endmodule

>>> hw/rtl/ows_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ows_step: one search event
// Takes the current search state and one item, gives the next state and the
// result item. Pure combinational logic between the stage and result registers.
// ----------------------------------------------------------------------------
module ows_step #(
  parameter int ROM_BITS = ows_pkg::ROM_BITS_DEF
) (
  input  ows_pkg::in_t         item,
  input  ows_pkg::ctl_t        ctl,
  input  logic [ROM_BITS-1:0]  rom,
  output ows_pkg::ctl_t        ctl_nxt,
  output logic [ROM_BITS-1:0]  rom_nxt,
  output ows_pkg::out_t        res
);

  localparam int IDX_W = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;
  localparam logic [ows_pkg::POS_W-1:0] LAST_POS = ows_pkg::POS_W'(ROM_BITS);

  logic [IDX_W-1:0]          idx;
  logic [ows_pkg::POS_W-1:0] pos_inc;
  logic                      dir;

  // Bit index of the current position and the following position
  assign idx     = IDX_W'(ctl.bit_position - ows_pkg::POS_W'(1));
  assign pos_inc = ctl.bit_position + ows_pkg::POS_W'(1);

  // Decide the step
  always_comb begin
    ctl_nxt = ctl;
    rom_nxt = rom;
    dir     = 1'b0;
    res     = '0;
    res.status = ows_pkg::ST_IDLE;

    case (item.req_type)
      ows_pkg::REQ_BEGIN: begin
        ctl_nxt.in_pass = 1'b0;
        if (ctl.last_device_found || !item.presence) begin
          ctl_nxt.last_discrepancy  = '0;
          ctl_nxt.last_device_found = 1'b0;
          ctl_nxt.family_branch     = '0;
          res.status = ows_pkg::ST_NOT_FOUND;
        end else begin
          ctl_nxt.in_pass            = 1'b1;
          ctl_nxt.bit_position       = ows_pkg::POS_W'(1);
          ctl_nxt.last_zero_position = '0;
          res.command_byte = item.normal_search ? ows_pkg::CMD_SEARCH
                                                : ows_pkg::CMD_COND_SEARCH;
          res.status = ows_pkg::ST_COMMAND;
        end
      end
      ows_pkg::REQ_BIT: begin
        if (ctl.in_pass) begin
          if (item.id_bit && item.complement_bit) begin
            // no device answers at this position
            ctl_nxt.in_pass           = 1'b0;
            ctl_nxt.last_discrepancy  = '0;
            ctl_nxt.last_device_found = 1'b0;
            ctl_nxt.family_branch     = '0;
            res.status = ows_pkg::ST_NOT_FOUND;
          end else begin
            if (item.id_bit != item.complement_bit) begin
              dir = item.id_bit;
            end else begin
              // discrepancy: follow the previous path, take the one branch at the last discrepancy, zero after it
              if (ctl.bit_position < ctl.last_discrepancy) begin
                dir = rom[idx];
              end else begin
                dir = (ctl.bit_position == ctl.last_discrepancy);
              end
              if (!dir) begin
                ctl_nxt.last_zero_position = ctl.bit_position;
                if (ctl.bit_position < ows_pkg::FAMILY_LIMIT) begin
                  ctl_nxt.family_branch = ctl.bit_position[ows_pkg::FAM_W-1:0];
                end
              end
            end
            rom_nxt[idx]         = dir;
            res.write_dir        = 1'b1;
            res.direction        = dir;
            res.status           = ows_pkg::ST_CONTINUE;
            ctl_nxt.bit_position = pos_inc;
            // close the pass after the last bit
            if (pos_inc > LAST_POS) begin
              ctl_nxt.in_pass          = 1'b0;
              ctl_nxt.last_discrepancy = ctl_nxt.last_zero_position;
              if (ctl_nxt.last_zero_position == '0) begin
                ctl_nxt.last_device_found = 1'b1;
              end
              if (rom_nxt[7:0] == 8'h00) begin
                ctl_nxt.last_discrepancy  = '0;
                ctl_nxt.last_device_found = 1'b0;
                ctl_nxt.family_branch     = '0;
                res.status = ows_pkg::ST_NOT_FOUND;
              end else begin
                res.status      = ows_pkg::ST_FOUND;
                res.rom_address = 64'(rom_nxt);
                res.last_device = ctl_nxt.last_device_found;
              end
            end
          end
        end
      end
      ows_pkg::REQ_CLEAR: begin
        ctl_nxt.in_pass           = 1'b0;
        ctl_nxt.last_discrepancy  = '0;
        ctl_nxt.last_device_found = 1'b0;
        ctl_nxt.family_branch     = '0;
      end
      default: begin
        // unused request: nothing changes
      end
    endcase

    res.family_discrepancy = ctl_nxt.family_branch;
  end

endmodule
